[src/array_shuffle_engine_assert.svh]
// Assertion macros for the array shuffle engine RTL, used by the datapath.
`ifndef ARRAY_SHUFFLE_ENGINE_ASSERT_SVH
`define ARRAY_SHUFFLE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge out of reset.
`define ASE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("array_shuffle_engine: invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array_shuffle_engine: implication violated");

`else

`define ASE_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

[src/ase_pkg.sv]
// Types and constants shared by the array shuffle engine modules.
`default_nettype none

package ase_pkg;

    // Fixed field widths of the beats.
    localparam int DATA_W = 32;
    localparam int RAND_W = 31;
    localparam int SIDX_W = 6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_STEP  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_PASS_DONE = 2'd2,
        ST_READ_END  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [DATA_W-1:0] element_value;
        logic [RAND_W-1:0]        random_word;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [SIDX_W-1:0]        swap_index;
        logic                     last_element;
        status_t                  status;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD_POS,
        S_RD_J,
        S_WR_POS,
        S_WR_J,
        S_RD_DATA,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic rd_pos;
        logic rd_j;
        logic wr_pos;
        logic wr_j;
        logic rd_data;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic pass_done;
        logic read_end;
        logic mod_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[src/array_shuffle_engine.sv]
// Top level of the array shuffle engine: controller and datapath.
//
//   Channel   Signals                              Direction
//   item      item_valid, item_stall, item         beats in (operation, element, random)
//   result    result_valid, result_stall, result   beats out (value, index, last, status)
//   cfg       cfg_wr_en, cfg_wr_data               shuffle mode register writes
//
// One item is worked on at a time. Clear and load pass from acceptance
// straight to hand-over; a read adds one registered read of the store.
// A shuffle step runs the bit-serial remainder (its bit steps and then
// its done flag), the swap in four states through the single write port
// of the store, and acceptance and hand-over.
// Reset clears the counters, the mode and the result valid; the store
// contents are left as they are and need no clearing pass.
// A finished beat waits in the result register; the next item is accepted
// meanwhile and holds in its last cycle until the register is free.
`default_nettype none

module array_shuffle_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire ase_pkg::in_beat_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output ase_pkg::out_beat_t      result
);

    ase_pkg::cmd_t  cmd;
    ase_pkg::stat_t status;

    // Sequencer.
    ase_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Store, counters and arithmetic.
    ase_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

[src/ase_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/ase_mod_unit.sv]
// Bit-serial restoring remainder unit: dividend modulo a narrow divisor.
`default_nettype none

module ase_mod_unit #(
    parameter int DIVISOR_W = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ase_pkg::RAND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]      divisor,
    output logic                           done,
    output logic      [DIVISOR_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(ase_pkg::RAND_W + 1);

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [ase_pkg::RAND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]       div_reg, div_next;
    logic [DIVISOR_W-1:0]       rem_reg, rem_next;
    logic [DIVISOR_W:0]         trial;
    logic [DIVISOR_W:0]         diff;

    // One dividend bit per cycle, most significant first. The partial
    // remainder stays below the divisor, so it fits the divisor width.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[ase_pkg::RAND_W-1]};
        diff      = trial - {1'b0, div_reg};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(ase_pkg::RAND_W);
            quo_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            quo_next  = {quo_reg[ase_pkg::RAND_W-2:0], 1'b0};
            rem_next  = (trial >= {1'b0, div_reg}) ? diff[DIVISOR_W-1:0]
                                                   : trial[DIVISOR_W-1:0];
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and remainder registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[src/ase_datapath.sv]
// Datapath: element store, counters, remainder unit and result registers.
`default_nettype none
`include "array_shuffle_engine_assert.svh"

module ase_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire ase_pkg::in_beat_t item,
    output ase_pkg::out_beat_t     result,
    output logic                   result_valid,
    input  wire logic              result_stall,
    input  wire ase_pkg::cmd_t     cmd,
    output ase_pkg::stat_t         status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              steps_reg, steps_next;
    logic [CW-1:0]              rptr_reg, rptr_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic                       mode_reg;
    logic [ase_pkg::DATA_W-1:0] tmp_reg, tmp_next;
    ase_pkg::out_beat_t         res_reg, res_next;
    ase_pkg::out_beat_t         out_reg;
    logic                       out_valid_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ase_pkg::DATA_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ase_pkg::DATA_W-1:0] ram_rdata;

    logic                       mod_start;
    logic [CW-1:0]              mod_divisor;
    logic                       mod_done;
    logic [CW-1:0]              mod_rem;

    logic [CW-1:0]              pos_desc;
    logic [CW-1:0]              rptr_plus;
    logic [AW-1:0]              j;
    logic [AW+ase_pkg::SIDX_W-1:0] j_ext;
    logic                       full;
    logic                       pass_done;
    logic                       read_end;
    logic                       out_free;

    ase_ram #(
        .WIDTH (ase_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ase_mod_unit #(
        .DIVISOR_W (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (item.random_word),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Conditions of the item on offer and of the result register.
    assign full      = (count_reg == CW'(DEPTH));
    assign pass_done = (steps_reg >= count_reg);
    assign read_end  = !(rptr_reg < count_reg);
    assign out_free  = !out_valid_reg || !result_stall;
    assign pos_desc  = count_reg - steps_reg - CW'(1);
    assign rptr_plus = rptr_reg + CW'(1);

    // Descending mode divides by position plus one, forward mode by the count.
    assign mod_divisor = mode_reg ? count_reg : (count_reg - steps_reg);

    // The remainder is below the divisor, hence below the depth.
    assign j     = mod_rem[AW-1:0];
    assign j_ext = {{ase_pkg::SIDX_W{1'b0}}, j};

    assign status.op        = item.operation;
    assign status.pass_done = pass_done;
    assign status.read_end  = read_end;
    assign status.mod_done  = mod_done;
    assign status.out_free  = out_free;

    // Next values of the counters, the store ports and the pending result.
    always_comb
    begin
        count_next = count_reg;
        steps_next = steps_reg;
        rptr_next  = rptr_reg;
        pos_next   = pos_reg;
        tmp_next   = tmp_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = item.element_value;
        ram_raddr  = pos_reg;
        mod_start  = 1'b0;

        if (cmd.take)
        begin
            res_next = '0;
            unique case (item.operation)
                ase_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                    steps_next = '0;
                    rptr_next  = '0;
                    pos_next   = '0;
                end
                ase_pkg::OP_LOAD:
                begin
                    if (full)
                    begin
                        res_next.status = ase_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        steps_next = '0;
                        rptr_next  = '0;
                    end
                end
                ase_pkg::OP_STEP:
                begin
                    if (pass_done)
                    begin
                        res_next.status = ase_pkg::ST_PASS_DONE;
                    end
                    else
                    begin
                        pos_next   = mode_reg ? steps_reg[AW-1:0] : pos_desc[AW-1:0];
                        mod_start  = 1'b1;
                        steps_next = steps_reg + CW'(1);
                    end
                end
                ase_pkg::OP_READ:
                begin
                    if (read_end)
                    begin
                        res_next.status = ase_pkg::ST_READ_END;
                    end
                    else
                    begin
                        ram_raddr             = rptr_reg[AW-1:0];
                        res_next.last_element = (rptr_plus == count_reg);
                        rptr_next             = rptr_plus;
                    end
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end

        // Swap sequence: read both entries, then write them crosswise.
        if (cmd.rd_pos)
        begin
            ram_raddr           = pos_reg;
            res_next.swap_index = j_ext[ase_pkg::SIDX_W-1:0];
        end
        if (cmd.rd_j)
        begin
            ram_raddr = j;
            tmp_next  = ram_rdata;
        end
        if (cmd.wr_pos)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = ram_rdata;
        end
        if (cmd.wr_j)
        begin
            ram_we    = 1'b1;
            ram_waddr = j;
            ram_wdata = tmp_reg;
        end
        if (cmd.rd_data)
        begin
            res_next.read_value = ram_rdata;
        end
    end

    // Control state: counters, mode register and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            steps_reg     <= '0;
            rptr_reg      <= '0;
            pos_reg       <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            steps_reg <= steps_next;
            rptr_reg  <= rptr_next;
            pos_reg   <= pos_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        res_reg <= res_next;
        if (cmd.publish)
        begin
            out_reg <= res_reg;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // Counter invariants and the hand-over into the result register.
    `ASE_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CW'(DEPTH))
    `ASE_ASSERT_ALWAYS(a_steps_bounded, clk, rst_n, steps_reg <= count_reg)
    `ASE_ASSERT_ALWAYS(a_rptr_bounded, clk, rst_n, rptr_reg <= count_reg)
    `ASE_ASSERT_IMPLY(a_publish_free, clk, rst_n, cmd.publish, !out_valid_reg || !result_stall)

endmodule

`default_nettype wire

[src/ase_ctrl.sv]
// Controller state machine sequencing each item through the datapath.
`default_nettype none

module ase_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire ase_pkg::stat_t status,
    output ase_pkg::cmd_t       cmd
);

    ase_pkg::state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ase_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (status.op)
                        ase_pkg::OP_CLEAR: state_next = ase_pkg::S_FINISH;
                        ase_pkg::OP_LOAD:  state_next = ase_pkg::S_FINISH;
                        ase_pkg::OP_STEP:  state_next = status.pass_done ? ase_pkg::S_FINISH
                                                                         : ase_pkg::S_DIV;
                        ase_pkg::OP_READ:  state_next = status.read_end ? ase_pkg::S_FINISH
                                                                        : ase_pkg::S_RD_DATA;
                        default:           state_next = ase_pkg::S_FINISH;
                    endcase
                end
            end
            ase_pkg::S_DIV:
            begin
                if (status.mod_done)
                begin
                    state_next = ase_pkg::S_RD_POS;
                end
            end
            ase_pkg::S_RD_POS:  state_next = ase_pkg::S_RD_J;
            ase_pkg::S_RD_J:    state_next = ase_pkg::S_WR_POS;
            ase_pkg::S_WR_POS:  state_next = ase_pkg::S_WR_J;
            ase_pkg::S_WR_J:    state_next = ase_pkg::S_FINISH;
            ase_pkg::S_RD_DATA: state_next = ase_pkg::S_FINISH;
            ase_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ase_pkg::S_IDLE;
                end
            end
            default:            state_next = ase_pkg::S_IDLE;
        endcase
    end

    // Commands and input stall.
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ase_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                cmd.take   = item_valid;
            end
            ase_pkg::S_DIV:     cmd = '0;
            ase_pkg::S_RD_POS:  cmd.rd_pos  = 1'b1;
            ase_pkg::S_RD_J:    cmd.rd_j    = 1'b1;
            ase_pkg::S_WR_POS:  cmd.wr_pos  = 1'b1;
            ase_pkg::S_WR_J:    cmd.wr_j    = 1'b1;
            ase_pkg::S_RD_DATA: cmd.rd_data = 1'b1;
            ase_pkg::S_FINISH:  cmd.publish = status.out_free;
            default:            cmd = '0;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ase_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
